@@ rtl/core/mbrfc_pkg.sv @@
// Package for the Modbus RTU frame checker: beat types, status codes, CRC-16 step.
// No dependencies; used by every module under rtl/core.
package mbrfc_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 256;
    localparam int unsigned HEADER_BYTES    = 6;
    localparam int unsigned CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned HDR_IDX_W       = $clog2(HEADER_BYTES);

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] CRC_RESIDUE = 16'h0000;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_HDR = CNT_W'(HEADER_BYTES);

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_EOF  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_CRC   = 2'd2,
        ST_SLAVE = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] rx_byte;
    } t_in_beat;

    typedef struct packed {
        t_status          status;
        logic [7:0]       slave_id;
        logic [7:0]       function_code;
        logic [15:0]      start_address;
        logic [15:0]      word_count;
        logic [CNT_W-1:0] frame_length;
    } t_out_beat;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/core/modbus_rtu_frame_checker_top.sv @@
// A result beat is built combinationally when its end-of-frame beat is accepted, then registered in the output entries.
// One input beat per cycle while a result entry is free; byte and end-of-frame beats both wait on a stalled output.
// Input ready drops only when both result entries are full.
// Reset (synchronous, active low): CRC 0xFFFF, count and header zero, own address zero.
// Top level of the Modbus RTU frame checker; depends on mbrfc_pkg, mbrfc_frame, mbrfc_skid.
module modbus_rtu_frame_checker_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mbrfc_pkg::t_in_beat  i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mbrfc_pkg::t_out_beat o_out_beat
);

    logic                 w_beat_en;
    logic                 w_res_push;
    logic                 w_space;
    mbrfc_pkg::t_out_beat w_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = w_space;
    assign w_beat_en   = i_in_valid && w_space;

    mbrfc_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_beat_en  (w_beat_en),
        .i_beat     (i_in_beat),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    mbrfc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_space (w_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_beat)
    );

endmodule

@@ rtl/core/mbrfc_frame.sv @@
// Frame state of the Modbus RTU frame checker: running CRC, byte count, header bytes,
// own address register and end-of-frame result build. Depends on mbrfc_pkg.
module mbrfc_frame (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_beat_en,
    input  mbrfc_pkg::t_in_beat  i_beat,
    output logic                 o_res_push,
    output mbrfc_pkg::t_out_beat o_res
);

    logic [7:0]                  r_own_addr;
    logic [15:0]                 r_crc;
    logic [15:0]                 n_crc;
    logic [mbrfc_pkg::CNT_W-1:0] r_cnt;
    logic [mbrfc_pkg::CNT_W-1:0] n_cnt;
    logic [7:0]                  r_hdr [mbrfc_pkg::HEADER_BYTES];
    logic                        w_byte;
    logic                        w_eof;
    mbrfc_pkg::t_status          w_status;

    assign w_byte = i_beat_en && (i_beat.opcode == mbrfc_pkg::OP_BYTE);
    assign w_eof  = i_beat_en && (i_beat.opcode == mbrfc_pkg::OP_EOF);

    always_comb begin
        n_crc = mbrfc_pkg::crc16_byte(r_crc, i_beat.rx_byte);
        n_cnt = (r_cnt < mbrfc_pkg::CNT_MAX) ? r_cnt + 1'b1 : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= 8'h00;
        end else if (i_cfg_we) begin
            r_own_addr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_eof) begin
            r_crc <= mbrfc_pkg::CRC_INIT;
            r_cnt <= '0;
            for (int i = 0; i < mbrfc_pkg::HEADER_BYTES; i++) begin
                r_hdr[i] <= 8'h00;
            end
        end else if (w_byte) begin
            r_crc <= n_crc;
            r_cnt <= n_cnt;
            if (r_cnt < mbrfc_pkg::CNT_HDR) begin
                r_hdr[r_cnt[mbrfc_pkg::HDR_IDX_W-1:0]] <= i_beat.rx_byte;
            end
        end
    end

    always_comb begin
        if (r_cnt < mbrfc_pkg::CNT_HDR) begin
            w_status = mbrfc_pkg::ST_SHORT;
        end else if (r_crc != mbrfc_pkg::CRC_RESIDUE) begin
            w_status = mbrfc_pkg::ST_CRC;
        end else if (r_hdr[0] != r_own_addr) begin
            w_status = mbrfc_pkg::ST_SLAVE;
        end else begin
            w_status = mbrfc_pkg::ST_OK;
        end
    end

    always_comb begin
        o_res_push          = w_eof;
        o_res.status        = w_status;
        o_res.slave_id      = r_hdr[0];
        o_res.function_code = r_hdr[1];
        o_res.start_address = {r_hdr[2], r_hdr[3]};
        o_res.word_count    = {r_hdr[4], r_hdr[5]};
        o_res.frame_length  = r_cnt;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mbrfc_pkg::CNT_MAX)
        else $error("byte count past frame limit");

    a_eof_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eof |=> (r_cnt == '0) && (r_crc == mbrfc_pkg::CRC_INIT) && (r_hdr[0] == 8'h00))
        else $error("frame state not cleared after end of frame");

    a_short_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eof && (w_status != mbrfc_pkg::ST_SHORT) |-> (r_cnt >= mbrfc_pkg::CNT_HDR))
        else $error("non-short status on short frame");

endmodule

@@ rtl/core/mbrfc_skid.sv @@
// Two-entry result register (main plus skid) for the Modbus RTU frame checker output.
// Depends on mbrfc_pkg.
module mbrfc_skid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mbrfc_pkg::t_out_beat i_data,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mbrfc_pkg::t_out_beat o_data
);

    logic                 r_main_vld;
    logic                 r_skid_vld;
    mbrfc_pkg::t_out_beat r_main;
    mbrfc_pkg::t_out_beat r_skid;
    logic                 w_pop;

    assign w_pop   = r_main_vld && i_ready;
    assign o_space = !r_skid_vld;
    assign o_valid = r_main_vld;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_vld || w_pop) begin
                r_main_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_pop) begin
            r_main_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_vld || w_pop) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    a_skid_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_main_vld)
        else $error("skid entry held without main entry");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> !i_push)
        else $error("result pushed while both entries full");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_main_vld && !i_ready |=> r_main_vld && $stable(r_main))
        else $error("stalled result changed");

endmodule

@@ verif/mbrfc_result_checker.sv @@
// Result checker for the Modbus RTU frame checker: watches the config, byte and result channels,
// predicts each end-of-frame result and compares it field by field with the result beat.
// Depends on mbrfc_pkg for the beat types, status codes and frame constants.
module mbrfc_result_checker
    import mbrfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_beat  i_in_beat,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_beat i_out_beat,
    output int        o_errors,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]       own_address_q;
    logic [15:0]      crc_q;
    logic [CNT_W-1:0] count_q;
    logic [7:0]       header_q [HEADER_BYTES];
    t_out_beat        results_q [$];

    function automatic logic [15:0] crc_after(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ data[i];
            r  = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic clear_frame();
        crc_q   = CRC_INIT;
        count_q = '0;
        for (int i = 0; i < HEADER_BYTES; i++) begin
            header_q[i] = 8'h00;
        end
    endtask

    task automatic absorb_beat(input t_in_beat b);
        t_out_beat r;
        t_status   st;
        if (b.opcode == OP_BYTE) begin
            if (count_q < CNT_HDR) begin
                header_q[count_q] = b.rx_byte;
            end
            crc_q = crc_after(crc_q, b.rx_byte);
            if (count_q < CNT_MAX) begin
                count_q = count_q + 1'b1;
            end
        end else begin
            if (count_q < CNT_HDR) begin
                st = ST_SHORT;
            end else if (crc_q != CRC_RESIDUE) begin
                st = ST_CRC;
            end else if (header_q[0] != own_address_q) begin
                st = ST_SLAVE;
            end else begin
                st = ST_OK;
            end
            r.status        = st;
            r.slave_id      = header_q[0];
            r.function_code = header_q[1];
            r.start_address = {header_q[2], header_q[3]};
            r.word_count    = {header_q[4], header_q[5]};
            r.frame_length  = count_q;
            results_q.push_back(r);
            clear_frame();
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin : watch_p
        t_out_beat want;
        if (!i_rst_n) begin
            own_address_q = 8'h00;
            clear_frame();
            results_q.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (results_q.size() == 0) begin
                    $display("%0t ns: result beat with none expected, expected nothing, actual %h",
                             $time, i_out_beat);
                    o_errors++;
                end else begin
                    want = results_q.pop_front();
                    check_field("status", 16'(want.status), 16'(i_out_beat.status));
                    check_field("slave_id", 16'(want.slave_id), 16'(i_out_beat.slave_id));
                    check_field("function_code", 16'(want.function_code),
                                16'(i_out_beat.function_code));
                    check_field("start_address", want.start_address, i_out_beat.start_address);
                    check_field("word_count", want.word_count, i_out_beat.word_count);
                    check_field("frame_length", 16'(want.frame_length),
                                16'(i_out_beat.frame_length));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                own_address_q = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                absorb_beat(i_in_beat);
            end
        end
        o_pending = results_q.size();
    end

endmodule

@@ verif/tb_modbus_rtu_frame_checker_top.sv @@
// Testbench top for the Modbus RTU frame checker: drives directed and random frames with
// random idle cycles and address changes, and gives the verdict.
// Depends on mbrfc_pkg, modbus_rtu_frame_checker_top and mbrfc_result_checker.
module tb_modbus_rtu_frame_checker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbrfc_pkg::*;

    localparam int IDLE_PCT      = 19;
    localparam int ITEM_TARGET   = 750;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES    = 4;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = 8'h00;
    logic       in_valid  = 1'b0;
    t_in_beat   in_beat   = '{opcode: OP_BYTE, rx_byte: 8'h00};
    logic       out_ready = 1'b0;
    logic       cfg_ready;
    logic       in_ready;
    logic       out_valid;
    t_out_beat  out_beat;

    int         errors;
    int         pending;
    int         items_sent = 0;
    logic       steady     = 1'b0;
    logic [7:0] own_addr   = 8'h00;
    logic [7:0] frame_bytes [$];

    modbus_rtu_frame_checker_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    mbrfc_result_checker u_result_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_beat  (out_beat),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2ms;
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_beat(input t_opcode op, input logic [7:0] data);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{opcode: op, rx_byte: data};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) begin
            send_beat(OP_BYTE, frame_bytes[i]);
        end
        send_beat(OP_EOF, 8'($urandom));
    endtask

    task automatic append_crc();
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (frame_bytes[i]) begin
            crc = crc16_byte(crc, frame_bytes[i]);
        end
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
    endtask

    // noise, corrupted or well-formed frame with random content
    task automatic build_frame(input logic long_frame);
        int kind;
        int body_len;
        int pos;
        kind = $urandom_range(99);
        frame_bytes.delete();
        if (!long_frame && kind < 15) begin
            repeat ($urandom_range(0, 10)) frame_bytes.push_back(8'($urandom));
        end else begin
            if (long_frame || $urandom_range(99) < 3) begin
                body_len = $urandom_range(250, 300);
            end else begin
                body_len = $urandom_range(4, 12);
            end
            frame_bytes.push_back(($urandom_range(99) < 70) ? own_addr : 8'($urandom));
            repeat (body_len - 1) frame_bytes.push_back(8'($urandom));
            append_crc();
            if (!long_frame && kind < 30) begin
                pos = $urandom_range(0, frame_bytes.size() - 1);
                frame_bytes[pos] = frame_bytes[pos] ^ 8'(1 << $urandom_range(0, 7));
            end
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_own_address(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        own_addr = value;
    endtask

    initial begin
        logic [7:0] phase_addr [NUM_PHASES];
        int         phase_end;
        phase_addr[0] = 8'hFF;
        phase_addr[1] = 8'($urandom_range(1, 254));
        phase_addr[2] = 8'h00;
        phase_addr[3] = 8'($urandom_range(1, 254));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(OP_EOF, 8'hFF);
        frame_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F};
        send_frame();
        frame_bytes = '{8'h00, 8'h03, 8'hFF, 8'hFF, 8'h00, 8'h00};
        append_crc();
        send_frame();
        frame_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
        send_frame();

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_own_address(phase_addr[p]);
            steady    = (p == 2);
            phase_end = items_sent + ITEM_TARGET / NUM_PHASES;
            build_frame(p == 1);
            send_frame();
            while (items_sent < phase_end) begin
                build_frame(1'b0);
                send_frame();
            end
        end
        steady = 1'b0;
        drain_results();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
